/* hw/rtl/apsp_pkg.sv */
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Shared types and constants: matrix entry layout, command codes and the
// controller state encoding.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int DIST_W = 20;
    localparam int CFG_W  = 5;

    localparam logic [DIST_W-1:0] DIST_MAX         = '1;
    localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 5'd16;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] val;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_IK_RD,
        ST_ROW,
        ST_RESP
    } state_t;

endpackage

/* hw/rtl/apsp_ram.sv */
// ----------------------------------------------------------------------------
// Distance matrix memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int AW = 8
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  apsp_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr_a,
    output apsp_pkg::entry_t rdata_a,
    input  logic [AW-1:0]   raddr_b,
    output apsp_pkg::entry_t rdata_b
);
    import apsp_pkg::*;

    entry_t mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hw/rtl/all_pairs_shortest_path_top.sv */
// ----------------------------------------------------------------------------
// All-pairs shortest path top level
// A write lands in the matrix when it is accepted, a read answers through
// ST_READ and ST_RESP, a clear sweeps every matrix address, and a run steps
// through ST_IK_RD and then ST_ROW for each row, one memory read-modify-write
// per ST_ROW cycle. One word is in work at a time. After reset the matrix
// clearing sweep runs first, and no input word is accepted until it finishes.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_top #(
    parameter int MAX_NODES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [apsp_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [3:0]                 s_row_node,
    input  logic [3:0]                 s_col_node,
    input  logic [15:0]                s_edge_weight,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_result_kind,
    output logic [apsp_pkg::DIST_W-1:0] m_distance,
    output logic                       m_reachable
);
    import apsp_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = 2 * NW;
    localparam int NCW = $clog2(MAX_NODES + 1);

    state_t          state_reg, state_next;
    logic [CFG_W-1:0] node_count_reg;
    logic [NCW-1:0]  n_reg, n_next;
    logic [NW-1:0]   k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [AW-1:0]   clr_reg, clr_next;
    entry_t          ik_reg, ik_next;
    logic            pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]   pipe_addr_reg, pipe_addr_next;
    logic            inside_reg, inside_next;
    logic            pend_kind_reg, pend_kind_next;
    logic [DIST_W-1:0] pend_dist_reg, pend_dist_next;
    logic            pend_reach_reg, pend_reach_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_kind_reg, m_kind_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;
    logic            m_reach_reg, m_reach_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr_a, raddr_b;
    entry_t          wdata, rdata_a, rdata_b;

    logic [NW-1:0]   row_idx, col_idx;
    logic            in_range, s_fire;
    cmd_t            cmd;
    logic [NCW-1:0]  n_limit;
    logic            j_last, i_last, k_last;
    logic [DIST_W:0] sum_wide;
    logic [DIST_W-1:0] sum_sat;
    logic            relax_we;

    apsp_ram #(.AW(AW)) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign cmd           = cmd_t'(s_command);
    assign row_idx       = NW'(s_row_node);
    assign col_idx       = NW'(s_col_node);
    assign in_range      = (32'(s_row_node) < MAX_NODES) && (32'(s_col_node) < MAX_NODES);
    assign n_limit       = (32'(node_count_reg) > MAX_NODES) ? NCW'(MAX_NODES)
                                                              : NCW'(node_count_reg);
    assign j_last        = (NCW'(j_reg) == n_reg - 1'b1);
    assign i_last        = (NCW'(i_reg) == n_reg - 1'b1);
    assign k_last        = (NCW'(k_reg) == n_reg - 1'b1);

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_distance    = m_dist_reg;
    assign m_reachable   = m_reach_reg;

    // Relaxation write-back: port A holds the k-to-j entry, port B the i-to-j entry.
    assign sum_wide = {1'b0, ik_reg.val} + {1'b0, rdata_a.val};
    assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    assign relax_we = pipe_valid_reg && ik_reg.ok && rdata_a.ok
                      && (!rdata_b.ok || (sum_sat < rdata_b.val));

    always_comb begin
        we    = 1'b0;
        waddr = pipe_addr_reg;
        wdata = '{ok: 1'b1, val: sum_sat};
        if (relax_we) begin
            we = 1'b1;
        end else if (state_reg == ST_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '{ok: (clr_reg[AW-1:NW] == clr_reg[NW-1:0]), val: '0};
        end else if (s_fire && (cmd == CMD_WRITE) && in_range) begin
            we    = 1'b1;
            waddr = {row_idx, col_idx};
            wdata = '{ok: 1'b1, val: DIST_W'(s_edge_weight)};
        end
    end

    always_comb begin
        raddr_a = {row_idx, col_idx};
        raddr_b = {i_reg, j_reg};
        case (state_reg)
            ST_IK_RD: raddr_a = {i_reg, k_reg};
            ST_ROW:   raddr_a = {k_reg, j_reg};
            default:  raddr_a = {row_idx, col_idx};
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        clr_next        = clr_reg;
        ik_next         = ik_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        inside_next     = inside_reg;
        pend_kind_next  = pend_kind_reg;
        pend_dist_next  = pend_dist_reg;
        pend_reach_next = pend_reach_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_dist_next     = m_dist_reg;
        m_reach_next    = m_reach_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (cmd)
                        CMD_CLEAR: begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_RUN: begin
                            n_next          = n_limit;
                            k_next          = '0;
                            i_next          = '0;
                            j_next          = '0;
                            pend_kind_next  = KIND_ACK;
                            pend_dist_next  = '0;
                            pend_reach_next = 1'b0;
                            state_next      = (n_limit == '0) ? ST_RESP : ST_IK_RD;
                        end
                        CMD_READ: begin
                            inside_next = in_range;
                            state_next  = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                pend_kind_next  = KIND_READ;
                pend_reach_next = inside_reg && rdata_a.ok;
                pend_dist_next  = (inside_reg && rdata_a.ok) ? rdata_a.val : '0;
                state_next      = ST_RESP;
            end
            ST_IK_RD: begin
                j_next     = '0;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                if (j_reg == '0) begin
                    ik_next = rdata_a;
                end
                pipe_valid_next = 1'b1;
                pipe_addr_next  = {i_reg, j_reg};
                j_next          = j_reg + 1'b1;
                if (j_last) begin
                    if (i_last) begin
                        i_next = '0;
                        k_next = k_reg + 1'b1;
                        state_next = k_last ? ST_RESP : ST_IK_RD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_IK_RD;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_dist_next  = pend_dist_reg;
                    m_reach_next = pend_reach_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        ik_reg         <= ik_next;
        pipe_addr_reg  <= pipe_addr_next;
        inside_reg     <= inside_next;
        pend_kind_reg  <= pend_kind_next;
        pend_dist_reg  <= pend_dist_next;
        pend_reach_reg <= pend_reach_next;
        m_kind_reg     <= m_kind_next;
        m_dist_reg     <= m_dist_next;
        m_reach_reg    <= m_reach_next;
    end

endmodule

/* tb/sv/tb_all_pairs_shortest_path_top.sv */
// ----------------------------------------------------------------------------
// All-pairs shortest path testbench
// Drives command words into the distance matrix block and checks every read
// answer and run acknowledgement against a bench matrix model or, for typed
// directed words, the table. A short table of directed words comes first.
// Random phases follow, each under its own node count, made mostly of
// clear, write, run and read sequences with some random noise words mixed in.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_top;
    import apsp_pkg::*;

    localparam int NODES       = 16;
    localparam int SETTLE      = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 11;
    localparam int PROBES      = 26;

    typedef struct packed {
        logic              kind;
        logic [DIST_W-1:0] distance;
        logic              reach;
    } answer_t;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] weight;
        bit          typed;
        answer_t     want;
    } probe_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data      = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command     = '0;
    logic [3:0]        s_row_node    = '0;
    logic [3:0]        s_col_node    = '0;
    logic [15:0]       s_edge_weight = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_result_kind;
    logic [DIST_W-1:0] m_distance;
    logic              m_reachable;

    logic [DIST_W-1:0] path_len [NODES][NODES];
    bit                path_ok  [NODES][NODES];
    logic [CFG_W-1:0]  cfg_nodes;
    answer_t           pending_answers [$];
    int                mismatches  = 0;
    int                phase_words = 0;
    int                stall_left  = 0;
    bit                steady      = 1'b0;

    logic [CFG_W-1:0] phase_nodes [PHASES] = '{
        5'd3, 5'd1, 5'd0, 5'd31, 5'd6, 5'd16, 5'd2, 5'd9
    };

    probe_t directed [PROBES] = '{
        '{CMD_READ,  4'd0,  4'd0,  16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b1}},
        '{CMD_READ,  4'd15, 4'd15, 16'hFFFF,  1'b1, '{KIND_READ, 20'd0,     1'b1}},
        '{CMD_READ,  4'd0,  4'd15, 16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b0}},
        '{CMD_READ,  4'd15, 4'd0,  16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b0}},
        '{CMD_RUN,   4'd0,  4'd0,  16'd0,     1'b1, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd0,  4'd1,  16'hFFFF,  1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd1,  4'd2,  16'hFFFF,  1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd2,  4'd15, 16'hFFFF,  1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd15, 4'd3,  16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd3,  4'd3,  16'd7,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd5,  4'd6,  16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd0,  4'd1,  16'd0,     1'b1, '{KIND_READ, 20'd65535, 1'b1}},
        '{CMD_READ,  4'd3,  4'd3,  16'd0,     1'b1, '{KIND_READ, 20'd7,     1'b1}},
        '{CMD_READ,  4'd5,  4'd6,  16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b1}},
        '{CMD_RUN,   4'd15, 4'd15, 16'hFFFF,  1'b1, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd0,  4'd15, 16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd0,  4'd3,  16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd3,  4'd3,  16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_WRITE, 4'd0,  4'd15, 16'd1,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_RUN,   4'd0,  4'd0,  16'd0,     1'b1, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd0,  4'd3,  16'd0,     1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_CLEAR, 4'd15, 4'd15, 16'hFFFF,  1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd0,  4'd1,  16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b0}},
        '{CMD_READ,  4'd3,  4'd3,  16'd0,     1'b1, '{KIND_READ, 20'd0,     1'b1}},
        '{CMD_WRITE, 4'd15, 4'd0,  16'hFFFF,  1'b0, '{KIND_ACK,  20'd0,     1'b0}},
        '{CMD_READ,  4'd15, 4'd0,  16'd0,     1'b1, '{KIND_READ, 20'd65535, 1'b1}}
    };

    all_pairs_shortest_path_top #(
        .MAX_NODES(NODES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_row_node   (s_row_node),
        .s_col_node   (s_col_node),
        .s_edge_weight(s_edge_weight),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_kind(m_result_kind),
        .m_distance   (m_distance),
        .m_reachable  (m_reachable)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_paths();
        for (int i = 0; i < NODES; i++) begin
            for (int j = 0; j < NODES; j++) begin
                path_len[i][j] = '0;
                path_ok[i][j]  = (i == j);
            end
        end
    endfunction

    function automatic void relax_paths();
        int          span;
        logic [20:0] total;
        span = (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
        for (int k = 0; k < span; k++) begin
            for (int i = 0; i < span; i++) begin
                for (int j = 0; j < span; j++) begin
                    if (path_ok[i][k] && path_ok[k][j]) begin
                        total = {1'b0, path_len[i][k]} + {1'b0, path_len[k][j]};
                        if (total > {1'b0, DIST_MAX}) begin
                            total = {1'b0, DIST_MAX};
                        end
                        if (!path_ok[i][j] || total[DIST_W-1:0] < path_len[i][j]) begin
                            path_len[i][j] = total[DIST_W-1:0];
                            path_ok[i][j]  = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic bit apply_command(input cmd_t cmd, input logic [3:0] row,
                                         input logic [3:0] col, input logic [15:0] weight,
                                         output answer_t ans);
        ans = '{KIND_ACK, '0, 1'b0};
        case (cmd)
            CMD_CLEAR: begin
                clear_paths();
                return 1'b0;
            end
            CMD_WRITE: begin
                path_len[row][col] = DIST_W'(weight);
                path_ok[row][col]  = 1'b1;
                return 1'b0;
            end
            CMD_RUN: begin
                relax_paths();
                return 1'b1;
            end
            default: begin
                ans.kind = KIND_READ;
                if (path_ok[row][col]) begin
                    ans.distance = path_len[row][col];
                    ans.reach    = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int node_span();
        if (cfg_nodes == 0) begin
            return 4;
        end
        return (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
    endfunction

    function automatic logic [3:0] pick_node(input int span);
        if ($urandom_range(0, 9) == 0) begin
            return 4'($urandom_range(0, 15));
        end
        return 4'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input cmd_t cmd, input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] weight, input bit typed, input answer_t want);
        int      gap;
        answer_t ans;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_command     <= cmd;
        s_row_node    <= row;
        s_col_node    <= col;
        s_edge_weight <= weight;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (apply_command(cmd, row, col, weight, ans)) begin
            pending_answers.push_back(typed ? want : ans);
        end
        phase_words++;
        @(negedge aclk);
    endtask

    task automatic send_random(input cmd_t cmd, input logic [3:0] row, input logic [3:0] col,
                               input logic [15:0] weight);
        send_word(cmd, row, col, weight, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
    endtask

    task automatic set_node_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_nodes = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_episode(input bit hold_after_run);
        int span;
        int edges;
        span = node_span();
        if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) != 0) begin
                send_random(CMD_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
            end
            edges = $urandom_range(1, (2 * span > 12) ? 12 : 2 * span);
            repeat (edges) send_random(CMD_WRITE, pick_node(span), pick_node(span),
                                       pick_weight());
            send_random(CMD_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
            if (hold_after_run) begin
                wait_drained();
            end
            repeat ($urandom_range(1, 4)) send_random(CMD_READ, pick_node(span),
                                                      pick_node(span), 16'($urandom));
        end else begin
            send_random(cmd_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                        pick_weight());
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = idle_len();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result word: kind %0d distance %0d reachable %0d",
                       m_result_kind, m_distance, m_reachable);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (m_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_result_kind);
                    mismatches++;
                end
                if (m_distance !== want.distance) begin
                    $error("distance: expected %0d, actual %0d", want.distance, m_distance);
                    mismatches++;
                end
                if (m_reachable !== want.reach) begin
                    $error("reachable: expected %0d, actual %0d", want.reach, m_reachable);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        clear_paths();
        cfg_nodes = NODE_COUNT_RESET;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        set_node_count(5'd16);
        foreach (directed[idx]) begin
            send_word(directed[idx].cmd, directed[idx].row, directed[idx].col,
                      directed[idx].weight, directed[idx].typed, directed[idx].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_node_count(phase_nodes[p]);
            steady      = (p == 1);
            phase_words = 0;
            run_episode(1'b1);
            while (phase_words < PHASE_WORDS) run_episode(1'b0);
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
